>>> src/ddfc_pkg.sv
// Shared types and constants for the disk drive function controller.
`default_nettype none
package ddfc_pkg;

    // Geometry of the disk store
    localparam int SECTOR_WORDS      = 338;
    localparam int HEAD_COUNT        = 8;
    localparam int SECTORS_PER_TRACK = 128;
    localparam int TRACK_COUNT       = 128;

    // Field widths
    localparam int WORD_W   = 12;
    localparam int ADDR_W   = 26;
    localparam int TRACK_W  = 7;
    localparam int HEAD_W   = 3;
    localparam int SECTOR_W = 7;
    localparam int REPLY_W  = 2;

    // Function code decoding (octal, as on the channel)
    localparam logic [WORD_W-1:0] FC_MASK       = 12'o7600;
    localparam logic [WORD_W-1:0] FC_READ       = 12'o1000;
    localparam logic [WORD_W-1:0] FC_WRITE      = 12'o1200;
    localparam logic [WORD_W-1:0] FC_TRACK      = 12'o1400;
    localparam logic [WORD_W-1:0] FC_HEAD       = 12'o1600;
    localparam logic [WORD_W-1:0] FC_STATUS     = 12'o1700;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_READ   = 2'd1,
        MODE_WRITE  = 2'd2,
        MODE_STATUS = 2'd3
    } t_mode;

    typedef enum logic [REPLY_W-1:0] {
        REPLY_NONE      = 2'd0,
        REPLY_DECLINED  = 2'd1,
        REPLY_PROCESSED = 2'd2,
        REPLY_ACCEPTED  = 2'd3
    } t_reply;

endpackage
`default_nettype wire

>>> src/disk_drive_function_controller.sv
// Top level of the disk drive function controller: request decode and sector transfer.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request per handshake:
//   either a 12-bit function code (i_operation = 0) or one I/O slot
//   (i_operation = 1) with the current channel-full flag and channel word.
//   Output channel (o_out_valid / i_out_ready) carries exactly one result per
//   request: function reply, memory read/write strobe with word address and
//   data, status word, and the updated channel-full flag.
//   Path: each request goes through the input register, then the result
//   register, before o_out_valid rises. Throughput: one request per cycle
//   while the receiver takes results; the sector start address needs one
//   constant multiply by the sector length, placed between the two
//   registers, and the word pointer is a plain increment.
//   Reset (i_rst_n low, synchronous) clears track, head, sector, word pointer,
//   mode and latched status, and empties both pipeline registers.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more request, then o_in_ready drops until the result
//   is taken. Drive state (pointer, mode) changes only as a request moves
//   into the result register, so stalls never change results.
`default_nettype none
module disk_drive_function_controller (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_operation,
    input  wire logic [ddfc_pkg::WORD_W-1:0]     i_func_code,
    input  wire logic                            i_channel_full,
    input  wire logic [ddfc_pkg::WORD_W-1:0]     i_write_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [ddfc_pkg::REPLY_W-1:0]         o_func_reply,
    output logic                                 o_mem_read,
    output logic                                 o_mem_write,
    output logic [ddfc_pkg::ADDR_W-1:0]          o_mem_address,
    output logic [ddfc_pkg::WORD_W-1:0]          o_mem_data,
    output logic                                 o_status_valid,
    output logic [ddfc_pkg::WORD_W-1:0]          o_status_word,
    output logic                                 o_channel_full_out
);
    import ddfc_pkg::*;

    // Input register
    logic                r_in_valid;
    logic                r_in_op;
    logic [WORD_W-1:0]   r_in_code;
    logic                r_in_full;
    logic [WORD_W-1:0]   r_in_wword;

    // Drive state
    logic [TRACK_W-1:0]  r_track;
    logic [HEAD_W-1:0]   r_head;
    logic [SECTOR_W-1:0] r_sector;
    logic [ADDR_W-1:0]   r_pointer;
    t_mode               r_mode;
    logic [WORD_W-1:0]   r_status;

    logic [TRACK_W-1:0]  n_track;
    logic [HEAD_W-1:0]   n_head;
    logic [SECTOR_W-1:0] n_sector;
    logic [ADDR_W-1:0]   n_pointer;
    t_mode               n_mode;
    logic [WORD_W-1:0]   n_status;

    // Result register
    logic                r_out_valid;
    t_reply              r_reply;
    logic                r_rd;
    logic                r_wr;
    logic [ADDR_W-1:0]   r_addr;
    logic [WORD_W-1:0]   r_data;
    logic                r_sval;
    logic [WORD_W-1:0]   r_sword;
    logic                r_full_out;

    t_reply              n_reply;
    logic                n_rd;
    logic                n_wr;
    logic [ADDR_W-1:0]   n_addr;
    logic [WORD_W-1:0]   n_data;
    logic                n_sval;
    logic [WORD_W-1:0]   n_sword;
    logic                n_full_out;

    // Handshake
    logic s_out_take;
    logic s_fire;
    logic s_in_take;

    assign s_out_take = !r_out_valid || i_out_ready;
    assign s_fire     = r_in_valid && s_out_take;
    assign o_in_ready = !r_in_valid || s_out_take;
    assign s_in_take  = i_in_valid && o_in_ready;

    // Sector start address: sector index times sector length, modulo 2^ADDR_W
    logic [SECTOR_W-1:0] s_new_sector;
    logic [ADDR_W-1:0]   s_idx;
    logic [ADDR_W-1:0]   s_start;
    logic                s_range_ok;

    assign s_new_sector = r_in_code[SECTOR_W-1:0];
    assign s_idx = (ADDR_W'(r_track) * ADDR_W'(HEAD_COUNT) + ADDR_W'(r_head))
                   * ADDR_W'(SECTORS_PER_TRACK) + ADDR_W'(s_new_sector);
    assign s_start = s_idx * ADDR_W'(SECTOR_WORDS);
    assign s_range_ok = (32'(r_track) < 32'(TRACK_COUNT))
                     && (32'(r_head) < 32'(HEAD_COUNT))
                     && (32'(s_new_sector) < 32'(SECTORS_PER_TRACK));

    always_comb begin
        n_track    = r_track;
        n_head     = r_head;
        n_sector   = r_sector;
        n_pointer  = r_pointer;
        n_mode     = r_mode;
        n_status   = r_status;
        n_reply    = REPLY_NONE;
        n_rd       = 1'b0;
        n_wr       = 1'b0;
        n_addr     = '0;
        n_data     = '0;
        n_sval     = 1'b0;
        n_sword    = '0;
        n_full_out = r_in_full;

        if (!r_in_op) begin
            unique case (r_in_code & FC_MASK)
                FC_READ, FC_WRITE: begin
                    n_mode   = ((r_in_code & FC_MASK) == FC_READ) ? MODE_READ : MODE_WRITE;
                    n_sector = s_new_sector;
                    if (s_range_ok) begin
                        n_pointer = s_start;
                        n_reply   = REPLY_ACCEPTED;
                    end else begin
                        n_reply   = REPLY_DECLINED;
                    end
                end
                FC_TRACK: begin
                    n_track = r_in_code[TRACK_W-1:0];
                    n_reply = REPLY_PROCESSED;
                end
                FC_HEAD: begin
                    if (r_in_code == FC_STATUS) begin
                        n_mode   = MODE_STATUS;
                        n_status = WORD_W'(r_sector);
                        n_sector = r_sector + SECTOR_W'(1);
                        n_reply  = REPLY_ACCEPTED;
                    end else begin
                        n_head  = r_in_code[HEAD_W-1:0];
                        n_reply = REPLY_PROCESSED;
                    end
                end
                default: begin
                    n_reply = REPLY_DECLINED;
                end
            endcase
        end else begin
            case (r_mode)
                MODE_READ: begin
                    if (!r_in_full) begin
                        n_rd       = 1'b1;
                        n_addr     = r_pointer;
                        n_pointer  = r_pointer + ADDR_W'(1);
                        n_full_out = 1'b1;
                    end
                end
                MODE_WRITE: begin
                    if (r_in_full) begin
                        n_wr       = 1'b1;
                        n_addr     = r_pointer;
                        n_data     = r_in_wword;
                        n_pointer  = r_pointer + ADDR_W'(1);
                        n_full_out = 1'b0;
                    end
                end
                MODE_STATUS: begin
                    n_sval     = 1'b1;
                    n_sword    = r_status;
                    n_full_out = 1'b1;
                    n_status   = '0;
                    n_mode     = MODE_NONE;
                end
                default: begin
                end
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_track     <= '0;
            r_head      <= '0;
            r_sector    <= '0;
            r_pointer   <= '0;
            r_mode      <= MODE_NONE;
            r_status    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s_out_take) begin
                r_out_valid <= r_in_valid;
            end
            if (s_fire) begin
                r_track   <= n_track;
                r_head    <= n_head;
                r_sector  <= n_sector;
                r_pointer <= n_pointer;
                r_mode    <= n_mode;
                r_status  <= n_status;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in_op    <= i_operation;
            r_in_code  <= i_func_code;
            r_in_full  <= i_channel_full;
            r_in_wword <= i_write_word;
        end
        if (s_fire) begin
            r_reply    <= n_reply;
            r_rd       <= n_rd;
            r_wr       <= n_wr;
            r_addr     <= n_addr;
            r_data     <= n_data;
            r_sval     <= n_sval;
            r_sword    <= n_sword;
            r_full_out <= n_full_out;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_func_reply       = r_reply;
    assign o_mem_read         = r_rd;
    assign o_mem_write        = r_wr;
    assign o_mem_address      = r_addr;
    assign o_mem_data         = r_data;
    assign o_status_valid     = r_sval;
    assign o_status_word      = r_sword;
    assign o_channel_full_out = r_full_out;

    // Checks
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_mem_read && o_mem_write))
        else $error("memory read and write in one result");

    a_status_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status_valid) |-> (o_func_reply == REPLY_NONE))
        else $error("status delivered with a function reply");

    a_idle_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_mem_read && !o_mem_write) |-> (o_mem_address == '0))
        else $error("address driven without memory access");

    a_status_clears_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_in_op && (r_mode == MODE_STATUS)) |=> (r_mode == MODE_NONE))
        else $error("status slot did not clear the mode");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(r_pointer) || !r_in_valid))
        else $error("pointer moved while result stalled");

endmodule
`default_nettype wire

>>> tb/sv/disk_drive_function_controller_tb.sv
// Self-checking testbench for the disk drive function controller.
`timescale 1ns / 1ps
module disk_drive_function_controller_tb;
    import ddfc_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 60;     // long receiver hold-off to back the block up
    localparam int PHASE_REQS  = 430;    // random requests per idling phase
    localparam int DRAIN_WAIT  = 8;      // settle cycles after the last result

    // One result as it leaves the block
    typedef struct packed {
        t_reply              reply;
        logic                rd;
        logic                wr;
        logic [ADDR_W-1:0]   addr;
        logic [WORD_W-1:0]   data;
        logic                sval;
        logic [WORD_W-1:0]   sword;
        logic                cfull;
    } slot_result_t;

    // One row of the directed table; typed rows carry their own expected result
    typedef struct {
        logic                op;
        logic [WORD_W-1:0]   code;
        logic                full;
        logic [WORD_W-1:0]   wword;
        bit                  typed;
        slot_result_t        res;
    } stim_row_t;

    localparam slot_result_t NO_TYPED = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_operation = 1'b0;
    logic [WORD_W-1:0]     i_func_code = '0;
    logic                  i_channel_full = 1'b0;
    logic [WORD_W-1:0]     i_write_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [REPLY_W-1:0]    o_func_reply;
    logic                  o_mem_read;
    logic                  o_mem_write;
    logic [ADDR_W-1:0]     o_mem_address;
    logic [WORD_W-1:0]     o_mem_data;
    logic                  o_status_valid;
    logic [WORD_W-1:0]     o_status_word;
    logic                  o_channel_full_out;

    disk_drive_function_controller uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_func_code        (i_func_code),
        .i_channel_full     (i_channel_full),
        .i_write_word       (i_write_word),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_func_reply       (o_func_reply),
        .o_mem_read         (o_mem_read),
        .o_mem_write        (o_mem_write),
        .o_mem_address      (o_mem_address),
        .o_mem_data         (o_mem_data),
        .o_status_valid     (o_status_valid),
        .o_status_word      (o_status_word),
        .o_channel_full_out (o_channel_full_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Typed expectation riding along with the request currently offered
    bit            row_typed = 1'b0;
    slot_result_t  row_expect = '0;

    // Idling knobs; stall_pct is read by the receiver so it moves with NBAs
    int            idle_pct = 0;
    int            stall_pct = 0;
    bit            hold_req = 1'b0;
    bit            hold_done = 1'b0;
    int            hold_left = 0;

    int            requests_sent = 0;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    slot_result_t  pending_results[$];

    // Drive state mirror: geometry latches, transfer pointer, mode, status
    logic [TRACK_W-1:0]   drv_track = '0;
    logic [HEAD_W-1:0]    drv_head = '0;
    logic [SECTOR_W-1:0]  drv_sector = '0;
    logic [ADDR_W-1:0]    drv_ptr = '0;
    t_mode                drv_mode = MODE_NONE;
    logic [WORD_W-1:0]    drv_status = '0;

    // Result of one request, advancing the mirrored drive state
    function automatic slot_result_t controller_response(input logic op,
                                                         input logic [WORD_W-1:0] code,
                                                         input logic full,
                                                         input logic [WORD_W-1:0] wword);
        slot_result_t r;
        int unsigned  idx;
        int unsigned  start;
        r = '0;
        r.reply = REPLY_NONE;
        r.cfull = full;
        if (!op) begin
            case (code & FC_MASK)
                FC_READ, FC_WRITE: begin
                    drv_mode = ((code & FC_MASK) == FC_READ) ? MODE_READ : MODE_WRITE;
                    drv_sector = code[SECTOR_W-1:0];
                    // out-of-range geometry keeps mode and sector but not the pointer
                    if (drv_track >= TRACK_COUNT || drv_head >= HEAD_COUNT ||
                            drv_sector >= SECTORS_PER_TRACK) begin
                        r.reply = REPLY_DECLINED;
                    end else begin
                        idx = 32'(drv_track);
                        idx = (idx * HEAD_COUNT + drv_head) * SECTORS_PER_TRACK + drv_sector;
                        start = idx * SECTOR_WORDS;
                        drv_ptr = start[ADDR_W-1:0];
                        r.reply = REPLY_ACCEPTED;
                    end
                end
                FC_TRACK: begin
                    drv_track = code[TRACK_W-1:0];
                    r.reply = REPLY_PROCESSED;
                end
                FC_HEAD: begin
                    if (code == FC_STATUS) begin
                        drv_mode = MODE_STATUS;
                        drv_status = {{(WORD_W-SECTOR_W){1'b0}}, drv_sector};
                        drv_sector = drv_sector + 1'b1;
                        r.reply = REPLY_ACCEPTED;
                    end else begin
                        drv_head = code[HEAD_W-1:0];
                        r.reply = REPLY_PROCESSED;
                    end
                end
                default: r.reply = REPLY_DECLINED;
            endcase
        end else begin
            case (drv_mode)
                MODE_READ: begin
                    if (!full) begin
                        r.rd = 1'b1;
                        r.addr = drv_ptr;
                        drv_ptr = drv_ptr + 1'b1;
                        r.cfull = 1'b1;
                    end
                end
                MODE_WRITE: begin
                    if (full) begin
                        r.wr = 1'b1;
                        r.addr = drv_ptr;
                        r.data = wword;
                        drv_ptr = drv_ptr + 1'b1;
                        r.cfull = 1'b0;
                    end
                end
                MODE_STATUS: begin
                    // status goes out once, whatever the channel holds
                    r.sval = 1'b1;
                    r.sword = drv_status;
                    r.cfull = 1'b1;
                    drv_status = '0;
                    drv_mode = MODE_NONE;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic slot_result_t typed_result(input t_reply reply, input logic rd,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic sval,
                                                  input logic [WORD_W-1:0] sword,
                                                  input logic cfull);
        slot_result_t r;
        r = '0;
        r.reply = reply;
        r.rd = rd;
        r.addr = addr;
        r.sval = sval;
        r.sword = sword;
        r.cfull = cfull;
        return r;
    endfunction

    // Scoreboard: results are checked first, so a result can never match the
    // request accepted on the same edge (it must pass both block registers anyway).
    always @(posedge i_clk) begin : scoreboard
        slot_result_t got;
        slot_result_t want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.reply = t_reply'(o_func_reply);
                got.rd    = o_mem_read;
                got.wr    = o_mem_write;
                got.addr  = o_mem_address;
                got.data  = o_mem_data;
                got.sval  = o_status_valid;
                got.sword = o_status_word;
                got.cfull = o_channel_full_out;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR %0t: result with no request pending", $realtime);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"ERROR %0t: reply %0d/%0d rd %0b/%0b wr %0b/%0b ",
                                      "addr %0d/%0d data %03h/%03h sval %0b/%0b ",
                                      "sword %03h/%03h full %0b/%0b (exp/got)"},
                                     $realtime, want.reply, got.reply, want.rd, got.rd,
                                     want.wr, got.wr, want.addr, got.addr,
                                     want.data, got.data, want.sval, got.sval,
                                     want.sword, got.sword, want.cfull, got.cfull);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = controller_response(i_operation, i_func_code, i_channel_full,
                                           i_write_word);
                if (row_typed)
                    want = row_expect;
                pending_results.push_back(want);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block fills up
    // and has to drop o_in_ready while requests keep coming.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: any handshake resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request; returns on the edge where it is accepted. Valid is
    // only lowered when an idle cycle is actually inserted.
    task automatic offer(input logic op, input logic [WORD_W-1:0] code, input logic full,
                         input logic [WORD_W-1:0] wword, input bit typed,
                         input slot_result_t res);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_func_code    <= code;
        i_channel_full <= full;
        i_write_word   <= wword;
        row_typed      <= typed;
        row_expect     <= res;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    // Mostly well-formed sequences (geometry, sector start, a burst of slots;
    // status request then one or two slots) with some stray codes and slots mixed in.
    task automatic run_random_requests(input int count);
        int  target;
        int  burst;
        bit  is_write;
        logic [WORD_W-1:0] start_code;
        target = requests_sent + count;
        while (requests_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if ($urandom_range(0, 2) != 0)
                        offer(1'b0, FC_TRACK | WORD_W'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)), WORD_W'($urandom_range(0, 4095)),
                              1'b0, NO_TYPED);
                    if ($urandom_range(0, 2) != 0)
                        offer(1'b0, FC_HEAD | WORD_W'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)), WORD_W'($urandom_range(0, 4095)),
                              1'b0, NO_TYPED);
                    is_write = 1'($urandom_range(0, 1));
                    start_code = is_write ? FC_WRITE : FC_READ;
                    offer(1'b0, start_code | WORD_W'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)), WORD_W'($urandom_range(0, 4095)),
                          1'b0, NO_TYPED);
                    // reads mostly see an empty channel, writes a full one
                    burst = $urandom_range(1, 10);
                    repeat (burst)
                        offer(1'b1, WORD_W'($urandom_range(0, 4095)),
                              is_write ? ($urandom_range(0, 3) != 0)
                                       : ($urandom_range(0, 3) == 0),
                              WORD_W'($urandom_range(0, 4095)), 1'b0, NO_TYPED);
                end
                6, 7: begin
                    offer(1'b0, FC_STATUS, 1'($urandom_range(0, 1)),
                          WORD_W'($urandom_range(0, 4095)), 1'b0, NO_TYPED);
                    repeat ($urandom_range(1, 2))
                        offer(1'b1, WORD_W'($urandom_range(0, 4095)),
                              1'($urandom_range(0, 1)), WORD_W'($urandom_range(0, 4095)),
                              1'b0, NO_TYPED);
                end
                8: offer(1'b0, WORD_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                         WORD_W'($urandom_range(0, 4095)), 1'b0, NO_TYPED);
                default: offer(1'b1, WORD_W'($urandom_range(0, 4095)),
                               1'($urandom_range(0, 1)), WORD_W'($urandom_range(0, 4095)),
                               1'b0, NO_TYPED);
            endcase
        end
    endtask

    initial begin : stimulus
        stim_row_t directed_rows[$];
        // after reset: idle slots, declined extremes, first read sector at zero
        directed_rows.push_back('{1'b1, 12'o0000, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_NONE, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b1, 12'o7777, 1'b1, 12'hFFF, 1'b1,
            typed_result(REPLY_NONE, 1'b0, '0, 1'b0, '0, 1'b1)});
        directed_rows.push_back('{1'b0, 12'o0000, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_DECLINED, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b0, 12'o7777, 1'b1, 12'hFFF, 1'b1,
            typed_result(REPLY_DECLINED, 1'b0, '0, 1'b0, '0, 1'b1)});
        directed_rows.push_back('{1'b0, FC_READ, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_ACCEPTED, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b1, 12'o0000, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_NONE, 1'b1, 26'd0, 1'b0, '0, 1'b1)});
        // read with the channel still full moves nothing
        directed_rows.push_back('{1'b1, 12'o0000, 1'b1, 12'h000, 1'b1,
            typed_result(REPLY_NONE, 1'b0, '0, 1'b0, '0, 1'b1)});
        directed_rows.push_back('{1'b1, 12'o7777, 1'b0, 12'hFFF, 1'b1,
            typed_result(REPLY_NONE, 1'b1, 26'd1, 1'b0, '0, 1'b1)});
        // last track, last head (not the status code), last sector
        directed_rows.push_back('{1'b0, FC_TRACK | 12'o177, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_PROCESSED, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b0, FC_HEAD | 12'o077, 1'b1, 12'h000, 1'b1,
            typed_result(REPLY_PROCESSED, 1'b0, '0, 1'b0, '0, 1'b1)});
        directed_rows.push_back('{1'b0, FC_READ | 12'o177, 1'b0, 12'h000, 1'b0, NO_TYPED});
        directed_rows.push_back('{1'b1, 12'o0000, 1'b0, 12'h000, 1'b0, NO_TYPED});
        directed_rows.push_back('{1'b0, FC_WRITE | 12'o177, 1'b0, 12'h000, 1'b0, NO_TYPED});
        // write with an empty channel moves nothing
        directed_rows.push_back('{1'b1, 12'o0000, 1'b0, 12'hFFF, 1'b0, NO_TYPED});
        directed_rows.push_back('{1'b1, 12'o0000, 1'b1, 12'hFFF, 1'b0, NO_TYPED});
        directed_rows.push_back('{1'b1, 12'o7777, 1'b1, 12'h000, 1'b0, NO_TYPED});
        // status at the last sector, sector wraps to zero
        directed_rows.push_back('{1'b0, FC_STATUS, 1'b1, 12'h000, 1'b1,
            typed_result(REPLY_ACCEPTED, 1'b0, '0, 1'b0, '0, 1'b1)});
        directed_rows.push_back('{1'b1, 12'o0000, 1'b0, 12'h000, 1'b0, NO_TYPED});
        // status was delivered once; mode is back to none
        directed_rows.push_back('{1'b1, 12'o0000, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_NONE, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b0, FC_TRACK, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_PROCESSED, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b0, FC_HEAD, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_PROCESSED, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b0, FC_STATUS, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_ACCEPTED, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b1, 12'o0000, 1'b1, 12'h000, 1'b1,
            typed_result(REPLY_NONE, 1'b0, '0, 1'b1, 12'h000, 1'b1)});
        // codes just outside the decoded window
        directed_rows.push_back('{1'b0, 12'o0777, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_DECLINED, 1'b0, '0, 1'b0, '0, 1'b0)});
        directed_rows.push_back('{1'b0, 12'o2000, 1'b0, 12'h000, 1'b1,
            typed_result(REPLY_DECLINED, 1'b0, '0, 1'b0, '0, 1'b0)});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            offer(directed_rows[k].op, directed_rows[k].code, directed_rows[k].full,
                  directed_rows[k].wword, directed_rows[k].typed, directed_rows[k].res);

        // no idling, with the long receiver hold-off at its start
        hold_req <= 1'b1;
        run_random_requests(PHASE_REQS);
        // sender idles
        idle_pct = 55;
        stall_pct <= 0;
        run_random_requests(PHASE_REQS);
        // receiver stalls
        idle_pct = 0;
        stall_pct <= 55;
        run_random_requests(PHASE_REQS);
        // both
        idle_pct = 23;
        stall_pct <= 23;
        run_random_requests(PHASE_REQS);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/ddfc_pkg.sv
src/disk_drive_function_controller.sv
tb/sv/disk_drive_function_controller_tb.sv
